// ===== rtl/nmea_pkg.sv =====
package nmea_pkg;

    // Character codes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Sentence headers, "$GPRMC" and "$GPGGA"
    localparam int HDR_LEN = 6;
    localparam logic [7:0] HDR_RMC [HDR_LEN] = '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};
    localparam logic [7:0] HDR_GGA [HDR_LEN] = '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41};

    // Header candidate codes
    localparam logic [1:0] CAND_NONE = 2'b00;
    localparam logic [1:0] CAND_RMC  = 2'b01;
    localparam logic [1:0] CAND_GGA  = 2'b10;
    localparam logic [1:0] CAND_BOTH = 2'b11;

    // Field numbers
    localparam logic [3:0] FLD_HEADER = 4'd0;
    localparam logic [3:0] FLD_TIME   = 4'd1;
    localparam logic [3:0] FLD_STATUS = 4'd2;
    localparam logic [3:0] FLD_LAT    = 4'd3;
    localparam logic [3:0] FLD_LON    = 4'd5;
    localparam logic [3:0] FLD_SPEED  = 4'd7;
    localparam logic [3:0] FLD_ALT    = 4'd9;
    localparam logic [3:0] CNT_MAX    = 4'd15;

    // Sentence kinds
    localparam logic KIND_RMC = 1'b0;
    localparam logic KIND_GGA = 1'b1;

    // Result field widths
    localparam int W_TIME  = 19;
    localparam int W_LAT   = 20;
    localparam int W_LON   = 23;
    localparam int W_SPEED = 24;
    localparam int W_ALT   = 28;
    localparam int W_DACC  = 23;

    // Digit weights of the fixed-format fields
    localparam logic [19:0] WT_TIME [6] = '{20'd36000, 20'd3600, 20'd600, 20'd60, 20'd10, 20'd1};
    localparam logic [19:0] WT_LAT  [7] = '{20'd60000, 20'd6000, 20'd1000, 20'd100, 20'd0,
                                            20'd10, 20'd1};
    localparam logic [19:0] WT_LON  [8] = '{20'd600000, 20'd60000, 20'd10000, 20'd1000,
                                            20'd100, 20'd0, 20'd10, 20'd1};

    // Control from the line parser to the number unit
    typedef struct packed {
        logic feed;
        logic clear;
    } t_num_ctrl;

    function automatic logic f_is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [3:0] f_digit(input logic [7:0] c);
        logic [7:0] d;
        d = c - CH_ZERO;
        return f_is_digit(c) ? d[3:0] : 4'd0;
    endfunction

    function automatic logic [19:0] f_weight(input logic [3:0] fld, input logic [3:0] pos);
        logic [19:0] w;
        w = '0;
        case (fld)
            FLD_TIME: if (pos < 4'd6) w = WT_TIME[pos[2:0]];
            FLD_LAT:  if (pos < 4'd7) w = WT_LAT[pos[2:0]];
            FLD_LON:  if (pos < 4'd8) w = WT_LON[pos[2:0]];
            default:  w = '0;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/nmea_rmc_gga_sentence_parser.sv =====
// Channel  Direction  Handshake                 Payload
// input    in         i_in_valid / o_in_ready   i_rx_byte
// output   out        o_out_valid / i_out_ready o_sentence_kind .. o_altitude_cm
//
// One character is accepted every cycle unless a stalled result holds back a line end;
// each enters an input register and is parsed in the next cycle, where a CR or LF loads a result.
// The line state and all accumulators update once per character in that single pass.
// Reset (i_rst_n low, synchronous) clears the line state and the stored record.
// A stalled result holds only line ends that produce a result; other characters flow.
module nmea_rmc_gga_sentence_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_sentence_kind,
    output logic [nmea_pkg::W_TIME-1:0]  o_time_of_day_s,
    output logic        o_fix_valid,
    output logic [nmea_pkg::W_LAT-1:0]   o_latitude_cmin,
    output logic [nmea_pkg::W_LON-1:0]   o_longitude_cmin,
    output logic [nmea_pkg::W_SPEED-1:0] o_speed_centi_kmh,
    output logic signed [nmea_pkg::W_ALT-1:0] o_altitude_cm
);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Line state
    logic [3:0] r_field, n_field;
    logic [3:0] r_pos, n_pos;
    logic [1:0] r_cand, n_cand;
    logic       r_stopped, n_stopped;
    logic [nmea_pkg::W_DACC-1:0] r_dacc, n_dacc;

    // Stored record
    logic [nmea_pkg::W_TIME-1:0]  r_st_time, n_st_time;
    logic                         r_st_valid, n_st_valid;
    logic [nmea_pkg::W_LAT-1:0]   r_st_lat, n_st_lat;
    logic [nmea_pkg::W_LON-1:0]   r_st_lon, n_st_lon;
    logic [nmea_pkg::W_SPEED-1:0] r_st_speed, n_st_speed;
    logic signed [nmea_pkg::W_ALT-1:0] r_st_alt, n_st_alt;

    // Result register
    logic                         r_out_valid;
    logic                         r_out_kind;
    logic [nmea_pkg::W_TIME-1:0]  r_out_time;
    logic                         r_out_fix;
    logic [nmea_pkg::W_LAT-1:0]   r_out_lat;
    logic [nmea_pkg::W_LON-1:0]   r_out_lon;
    logic [nmea_pkg::W_SPEED-1:0] r_out_speed;
    logic signed [nmea_pkg::W_ALT-1:0] r_out_alt;

    logic       is_eol, is_comma;
    logic       emit, advance, slot_free;
    logic [1:0] cand_end;
    logic       num_feed, num_clear;
    logic [19:0] weight;
    nmea_pkg::t_num_ctrl num_ctrl;
    logic [nmea_pkg::W_SPEED-1:0] num_speed;
    logic signed [nmea_pkg::W_ALT-1:0] num_alt;

    nmea_number u_number (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (num_ctrl),
        .i_char      (r_in_byte),
        .i_pos_first (r_pos == 4'd0),
        .o_speed     (num_speed),
        .o_altitude  (num_alt)
    );

    // Parse the held character
    always_comb begin
        is_eol     = (r_in_byte == nmea_pkg::CH_CR) || (r_in_byte == nmea_pkg::CH_LF);
        is_comma   = (r_in_byte == nmea_pkg::CH_COMMA);
        weight     = nmea_pkg::f_weight(r_field, r_pos);
        n_field    = r_field;
        n_pos      = r_pos;
        n_cand     = r_cand;
        n_stopped  = r_stopped;
        n_dacc     = r_dacc;
        n_st_time  = r_st_time;
        n_st_valid = r_st_valid;
        n_st_lat   = r_st_lat;
        n_st_lon   = r_st_lon;
        n_st_speed = r_st_speed;
        n_st_alt   = r_st_alt;
        num_feed   = 1'b0;
        num_clear  = 1'b0;
        emit       = 1'b0;
        cand_end   = r_cand;
        if (is_eol || is_comma) begin
            // close the field
            if (r_field == nmea_pkg::FLD_HEADER) begin
                if (r_pos != 4'(nmea_pkg::HDR_LEN)) n_cand = nmea_pkg::CAND_NONE;
            end else if (r_cand == nmea_pkg::CAND_RMC) begin
                if (!r_stopped && (r_field <= nmea_pkg::FLD_SPEED)) begin
                    if (r_pos == 4'd0) begin
                        n_stopped = 1'b1;
                    end else begin
                        case (r_field)
                            nmea_pkg::FLD_TIME:   n_st_time  = r_dacc[nmea_pkg::W_TIME-1:0];
                            nmea_pkg::FLD_STATUS: n_st_valid = r_dacc[0];
                            nmea_pkg::FLD_LAT:    n_st_lat   = r_dacc[nmea_pkg::W_LAT-1:0];
                            nmea_pkg::FLD_LON:    n_st_lon   = r_dacc;
                            nmea_pkg::FLD_SPEED:  n_st_speed = num_speed;
                            default:              n_st_lat   = r_st_lat;
                        endcase
                    end
                end
            end else if ((r_cand == nmea_pkg::CAND_GGA) && (r_field == nmea_pkg::FLD_ALT)) begin
                n_st_alt = num_alt;
            end
            if (r_field != nmea_pkg::CNT_MAX) n_field = r_field + 4'd1;
            n_pos     = '0;
            n_dacc    = '0;
            num_clear = 1'b1;
            cand_end  = n_cand;
            if (is_eol) begin
                // emit on a recognized line, then restart the line
                emit      = (n_cand == nmea_pkg::CAND_RMC) || (n_cand == nmea_pkg::CAND_GGA);
                n_field   = nmea_pkg::FLD_HEADER;
                n_cand    = nmea_pkg::CAND_BOTH;
                n_stopped = 1'b0;
            end
        end else begin
            if (r_field == nmea_pkg::FLD_HEADER) begin
                if (r_pos < 4'(nmea_pkg::HDR_LEN)) begin
                    if (nmea_pkg::HDR_RMC[r_pos[2:0]] != r_in_byte) n_cand[0] = 1'b0;
                    if (nmea_pkg::HDR_GGA[r_pos[2:0]] != r_in_byte) n_cand[1] = 1'b0;
                end else begin
                    n_cand = nmea_pkg::CAND_NONE;
                end
            end else if (r_cand == nmea_pkg::CAND_RMC) begin
                case (r_field)
                    nmea_pkg::FLD_TIME, nmea_pkg::FLD_LAT, nmea_pkg::FLD_LON: begin
                        n_dacc = r_dacc + 23'(nmea_pkg::f_digit(r_in_byte)) * 23'(weight);
                    end
                    nmea_pkg::FLD_STATUS: begin
                        if (r_pos == 4'd0) n_dacc = {22'd0, r_in_byte == nmea_pkg::CH_A};
                    end
                    nmea_pkg::FLD_SPEED: num_feed = 1'b1;
                    default:             num_feed = 1'b0;
                endcase
            end else if ((r_cand == nmea_pkg::CAND_GGA) && (r_field == nmea_pkg::FLD_ALT)) begin
                num_feed = 1'b1;
            end
            if (r_pos != nmea_pkg::CNT_MAX) n_pos = r_pos + 4'd1;
        end
    end

    // Handshake: a character advances unless it emits into a full result slot
    assign slot_free  = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (!emit || slot_free);
    assign o_in_ready = !r_in_valid || advance;
    assign num_ctrl   = '{feed: num_feed && advance, clear: num_clear && advance};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_field     <= nmea_pkg::FLD_HEADER;
            r_pos       <= '0;
            r_cand      <= nmea_pkg::CAND_BOTH;
            r_stopped   <= 1'b0;
            r_dacc      <= '0;
            r_st_time   <= '0;
            r_st_valid  <= 1'b0;
            r_st_lat    <= '0;
            r_st_lon    <= '0;
            r_st_speed  <= '0;
            r_st_alt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // load the input register
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            // commit the parse
            if (advance) begin
                r_field    <= n_field;
                r_pos      <= n_pos;
                r_cand     <= n_cand;
                r_stopped  <= n_stopped;
                r_dacc     <= n_dacc;
                r_st_time  <= n_st_time;
                r_st_valid <= n_st_valid;
                r_st_lat   <= n_st_lat;
                r_st_lon   <= n_st_lon;
                r_st_speed <= n_st_speed;
                r_st_alt   <= n_st_alt;
            end
            // hold or release the result beat
            if (advance && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Input byte and result payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) r_in_byte <= i_rx_byte;
        if (advance && emit) begin
            r_out_kind  <= (cand_end == nmea_pkg::CAND_GGA) ? nmea_pkg::KIND_GGA
                                                             : nmea_pkg::KIND_RMC;
            r_out_time  <= n_st_time;
            r_out_fix   <= n_st_valid;
            r_out_lat   <= n_st_lat;
            r_out_lon   <= n_st_lon;
            r_out_speed <= n_st_speed;
            r_out_alt   <= n_st_alt;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_sentence_kind   = r_out_kind;
    assign o_time_of_day_s   = r_out_time;
    assign o_fix_valid       = r_out_fix;
    assign o_latitude_cmin   = r_out_lat;
    assign o_longitude_cmin  = r_out_lon;
    assign o_speed_centi_kmh = r_out_speed;
    assign o_altitude_cm     = r_out_alt;

endmodule

// ===== rtl/nmea_number.sv =====
module nmea_number (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  nmea_pkg::t_num_ctrl      i_ctrl,
    input  logic [7:0]               i_char,
    input  logic                     i_pos_first,
    output logic [nmea_pkg::W_SPEED-1:0]   o_speed,
    output logic signed [nmea_pkg::W_ALT-1:0] o_altitude
);

    // Magnitude capped at 2^28: anything that large saturates the altitude
    localparam logic [28:0] ACC_CAP   = 29'h1000_0000;
    // Speed quotient capped at 2^24: anything that large saturates the speed
    localparam logic [24:0] Q_CAP     = 25'h100_0000;
    localparam logic [23:0] SPEED_MAX = 24'hFF_FFFF;
    localparam int          RADIX     = 10000;
    localparam int          KNOT_MUL  = 1852;

    logic [28:0] r_acc, n_acc;
    logic [24:0] r_q, n_q;
    logic [13:0] r_rem, n_rem;
    logic [1:0]  r_fc, n_fc;
    logic        r_neg, n_neg;
    logic        r_point, n_point;
    logic        r_ended, n_ended;

    logic [3:0]  dig;
    logic [32:0] acc_sum;
    logic [28:0] acc_dig;
    logic [16:0] rem_t;
    logic [3:0]  carry;
    logic [13:0] rem_dig;
    logic [28:0] q_sum;
    logic [24:0] q_dig;

    // Next digit: magnitude for altitude, and speed*1852 kept as quotient/remainder of 10^4
    always_comb begin
        dig     = nmea_pkg::f_digit(i_char);
        acc_sum = {4'd0, r_acc} * 33'd10 + {29'd0, dig};
        acc_dig = ((r_acc >= ACC_CAP) || (acc_sum >= {4'd0, ACC_CAP})) ? ACC_CAP : acc_sum[28:0];
        rem_t   = {3'd0, r_rem} * 17'd10 + {13'd0, dig} * 17'(KNOT_MUL);
        carry   = '0;
        for (int k = 1; k <= 11; k++) begin
            if (rem_t >= 17'(k * RADIX)) carry = 4'(k);
        end
        rem_dig = 14'(rem_t - {13'd0, carry} * 17'(RADIX));
        q_sum   = {4'd0, r_q} * 29'd10 + {25'd0, carry};
        q_dig   = ((r_q >= Q_CAP) || (q_sum >= {4'd0, Q_CAP})) ? Q_CAP : q_sum[24:0];
    end

    // Advance the number syntax
    always_comb begin
        n_acc   = r_acc;
        n_q     = r_q;
        n_rem   = r_rem;
        n_fc    = r_fc;
        n_neg   = r_neg;
        n_point = r_point;
        n_ended = r_ended;
        if (i_ctrl.clear) begin
            n_acc   = '0;
            n_q     = '0;
            n_rem   = '0;
            n_fc    = '0;
            n_neg   = 1'b0;
            n_point = 1'b0;
            n_ended = 1'b0;
        end else if (i_ctrl.feed && !r_ended) begin
            if (((i_char == nmea_pkg::CH_MINUS) || (i_char == nmea_pkg::CH_PLUS))
                    && i_pos_first) begin
                n_neg = (i_char == nmea_pkg::CH_MINUS);
            end else if (nmea_pkg::f_is_digit(i_char)) begin
                // drop fraction digits past the third
                if (!(r_point && (r_fc == 2'd3))) begin
                    if (r_point) n_fc = r_fc + 2'd1;
                    // the third fraction digit is truncated away from the altitude
                    if (!(r_point && (r_fc == 2'd2))) n_acc = acc_dig;
                    n_q   = q_dig;
                    n_rem = rem_dig;
                end
            end else if ((i_char == nmea_pkg::CH_POINT) && !r_point) begin
                n_point = 1'b1;
            end else begin
                n_ended = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_q     <= '0;
            r_rem   <= '0;
            r_fc    <= '0;
            r_neg   <= 1'b0;
            r_point <= 1'b0;
            r_ended <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_q     <= n_q;
            r_rem   <= n_rem;
            r_fc    <= n_fc;
            r_neg   <= n_neg;
            r_point <= n_point;
            r_ended <= n_ended;
        end
    end

    // Speed: scale quotient up by the missing fraction digits, add the scaled remainder
    logic [29:0] p10, p100, p1000;
    logic [34:0] spd_base;

    always_comb begin
        p10   = {16'd0, r_rem} * 30'd52429;
        p100  = {16'd0, r_rem} * 30'd5243;
        p1000 = {16'd0, r_rem} * 30'd8389;
        case (r_fc)
            2'd3:    spd_base = {11'd0, r_q[23:0]};
            2'd2:    spd_base = {11'd0, r_q[23:0]} * 35'd10 + {31'd0, p1000[26:23]};
            2'd1:    spd_base = {11'd0, r_q[23:0]} * 35'd100 + {28'd0, p100[25:19]};
            default: spd_base = {11'd0, r_q[23:0]} * 35'd1000 + {25'd0, p10[28:19]};
        endcase
        if (r_neg) begin
            o_speed = '0;
        end else if ((r_q >= Q_CAP) || (spd_base > {11'd0, SPEED_MAX})) begin
            o_speed = SPEED_MAX;
        end else begin
            o_speed = spd_base[23:0];
        end
    end

    // Altitude: centimetres from the magnitude, signed and saturated
    logic [35:0] mag;
    logic [27:0] alt_u;

    always_comb begin
        case (r_fc)
            2'd0:    mag = {7'd0, r_acc} * 36'd100;
            2'd1:    mag = {7'd0, r_acc} * 36'd10;
            default: mag = {7'd0, r_acc};
        endcase
        if (r_neg) begin
            alt_u = (mag > 36'h800_0000) ? 28'h800_0000 : (~mag[27:0] + 28'd1);
        end else begin
            alt_u = (mag > 36'h7FF_FFFF) ? 28'h7FF_FFFF : mag[27:0];
        end
        o_altitude = $signed(alt_u);
    end

endmodule

// ===== rtl/nmea_checker.sv =====
module nmea_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic        o_sentence_kind,
    input  logic [nmea_pkg::W_TIME-1:0]  o_time_of_day_s,
    input  logic        o_fix_valid,
    input  logic [nmea_pkg::W_LAT-1:0]   o_latitude_cmin,
    input  logic [nmea_pkg::W_LON-1:0]   o_longitude_cmin,
    input  logic [nmea_pkg::W_SPEED-1:0] o_speed_centi_kmh,
    input  logic signed [nmea_pkg::W_ALT-1:0] o_altitude_cm
);

    // Hold a result beat, payload unchanged, until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid
            && $stable({o_sentence_kind, o_time_of_day_s, o_fix_valid, o_latitude_cmin,
                        o_longitude_cmin, o_speed_centi_kmh, o_altitude_cm}))
        else $error("result beat dropped or changed while stalled");

    // Hold an input beat, payload unchanged, until it is taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_rx_byte))
        else $error("input beat dropped or changed while stalled");

    // Reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Time of day is a sum of six weighted digits
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_time_of_day_s <= 19'd362439)
        else $error("time of day out of range");

    // Positions are sums of weighted digits
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_latitude_cmin <= 20'd603999) && (o_longitude_cmin <= 23'd6039999))
        else $error("position out of range");

endmodule

bind nmea_rmc_gga_sentence_parser nmea_checker u_nmea_checker (.*);
